>>> sv/led_blink_pattern_engine_unit_defines.svh
// Assertion macros for the LED blink pattern engine.
// Used by led_blink_pattern_engine_unit.sv; no other dependencies.
`ifndef LED_BLINK_PATTERN_ENGINE_UNIT_DEFINES_SVH
`define LED_BLINK_PATTERN_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication
`define LBPE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbpe assertion failed");

// next-cycle implication
`define LBPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbpe assertion failed");

`endif

>>> sv/lbpe_pkg.sv
// Types and constants for the LED blink pattern engine.
// No dependencies.
package lbpe_pkg;

    localparam int INTERVALS = 8;
    localparam int IDX_W     = (INTERVALS > 1) ? $clog2(INTERVALS) : 1;
    localparam int HALF      = INTERVALS / 2;

    localparam logic       ACT_SET    = 1'b0;
    localparam logic       ACT_TICK   = 1'b1;

    localparam logic [2:0] LED_BOTTOM = 3'd1;
    localparam logic [2:0] LED_MIDDLE = 3'd3;
    localparam logic [2:0] LED_TOP    = 3'd4;

    localparam logic [1:0] COLOR_OFF   = 2'd0;
    localparam logic [1:0] COLOR_AMBER = 2'd1;
    localparam logic [1:0] COLOR_GREEN = 2'd2;
    localparam logic [1:0] COLOR_BAD   = 2'd3;

    localparam logic [1:0] MODE_STEADY = 2'd0;
    localparam logic [1:0] MODE_SLOW   = 2'd1;
    localparam logic [1:0] MODE_FAST   = 2'd2;
    localparam logic [1:0] MODE_BAD    = 2'd3;

    localparam logic [7:0] MASK_BOTTOM  = 8'h0c;
    localparam logic [7:0] AMBER_BOTTOM = 8'h08;
    localparam logic [7:0] GREEN_BOTTOM = 8'h04;
    localparam logic [7:0] MASK_MIDDLE  = 8'hc0;
    localparam logic [7:0] AMBER_MIDDLE = 8'h80;
    localparam logic [7:0] GREEN_MIDDLE = 8'h40;
    localparam logic [7:0] MASK_TOP     = 8'h03;
    localparam logic [7:0] AMBER_TOP    = 8'h02;
    localparam logic [7:0] GREEN_TOP    = 8'h01;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LED   = 2'd1,
        ST_BAD_COLOR = 2'd2,
        ST_BAD_MODE  = 2'd3
    } t_status;

    typedef struct packed {
        logic       action;
        logic [2:0] led_id;
        logic [1:0] color;
        logic [1:0] blink_mode;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic       byte_index;
        logic [7:0] byte_value;
        logic       last;
    } t_out_item;

endpackage

>>> sv/led_blink_pattern_engine_unit.sv
// LED blink pattern engine top level: sequencer, pattern store, output register.
// Depends on lbpe_pkg and led_blink_pattern_engine_unit_defines.svh.
//
// One request at a time. A set request walks the pattern store one interval
// per cycle through a single mask-and-merge unit and then reports its status;
// a rejected set reports its status without touching the store. A tick reads
// one store entry and then offers up to two byte updates.
// Results sit in an output register; back-pressure there stretches the request.
`include "led_blink_pattern_engine_unit_defines.svh"

module led_blink_pattern_engine_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lbpe_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lbpe_pkg::t_out_item o_out
);
    import lbpe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SET,
        S_RES,
        S_TICK,
        S_EMIT0,
        S_EMIT1
    } t_state;

    t_state          r_state;
    logic [1:0][7:0] r_store [INTERVALS];
    logic [1:0][7:0] r_last_sent;
    logic [1:0][7:0] r_entry;
    logic [1:0]      r_diff;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_cnt;
    logic            r_byte;
    logic [7:0]      r_mask;
    logic [7:0]      r_on;
    logic [1:0]      r_mode;
    t_status         r_status;
    t_out_item       r_out;
    logic            r_out_valid;

    logic [IDX_W-1:0] n_idx;
    logic            w_lit;
    logic [7:0]      w_merged;
    logic            w_out_free;
    logic            w_out_load;
    logic            w_accept;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_out_load = w_out_free && ((r_state == S_RES) ||
                                       (r_state == S_EMIT0 && r_diff[0]) ||
                                       (r_state == S_EMIT1 && r_diff[1]));
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign n_idx = (r_idx == IDX_W'(INTERVALS - 1)) ? '0 : r_idx + 1'b1;

    always_comb begin
        unique case (r_mode)
            MODE_STEADY: w_lit = 1'b1;
            MODE_SLOW:   w_lit = ({1'b0, r_cnt} < (IDX_W + 1)'(HALF));
            MODE_FAST:   w_lit = r_cnt[0];
            default:     w_lit = 1'b0;
        endcase
    end

    // shared merge unit
    assign w_merged = (r_store[r_cnt][r_byte] & ~r_mask) | (w_lit ? r_on : 8'h00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_last_sent <= '0;
            for (int k = 0; k < INTERVALS; k++) begin
                r_store[k] <= '0;
            end
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode <= i_in.blink_mode;
                        r_cnt  <= '0;
                        if (i_in.action == ACT_TICK) begin
                            r_idx   <= n_idx;
                            r_state <= S_TICK;
                        end else begin
                            priority case (i_in.led_id)
                                LED_BOTTOM: begin
                                    r_byte <= 1'b0;
                                    r_mask <= MASK_BOTTOM;
                                    r_on   <= (i_in.color == COLOR_OFF)   ? 8'h00 :
                                              (i_in.color == COLOR_AMBER) ? AMBER_BOTTOM
                                                                          : GREEN_BOTTOM;
                                end
                                LED_MIDDLE: begin
                                    r_byte <= 1'b0;
                                    r_mask <= MASK_MIDDLE;
                                    r_on   <= (i_in.color == COLOR_OFF)   ? 8'h00 :
                                              (i_in.color == COLOR_AMBER) ? AMBER_MIDDLE
                                                                          : GREEN_MIDDLE;
                                end
                                default: begin
                                    r_byte <= 1'b1;
                                    r_mask <= MASK_TOP;
                                    r_on   <= (i_in.color == COLOR_OFF)   ? 8'h00 :
                                              (i_in.color == COLOR_AMBER) ? AMBER_TOP
                                                                          : GREEN_TOP;
                                end
                            endcase
                            priority if (i_in.led_id != LED_BOTTOM &&
                                         i_in.led_id != LED_MIDDLE &&
                                         i_in.led_id != LED_TOP) begin
                                r_status <= ST_BAD_LED;
                                r_state  <= S_RES;
                            end else if (i_in.color == COLOR_BAD) begin
                                r_status <= ST_BAD_COLOR;
                                r_state  <= S_RES;
                            end else if (i_in.blink_mode == MODE_BAD) begin
                                r_status <= ST_BAD_MODE;
                                r_state  <= S_RES;
                            end else begin
                                r_status <= ST_OK;
                                r_state  <= S_SET;
                            end
                        end
                    end
                end
                S_SET: begin
                    r_store[r_cnt][r_byte] <= w_merged;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == IDX_W'(INTERVALS - 1)) begin
                        r_state <= S_RES;
                    end
                end
                S_RES: begin
                    if (w_out_free) begin
                        r_out       <= '{status: r_status, byte_index: 1'b0,
                                         byte_value: 8'h00, last: 1'b1};
                        r_state     <= S_IDLE;
                    end
                end
                S_TICK: begin
                    r_entry   <= r_store[r_idx];
                    r_diff[0] <= (r_store[r_idx][0] != r_last_sent[0]);
                    r_diff[1] <= (r_store[r_idx][1] != r_last_sent[1]);
                    r_state   <= S_EMIT0;
                end
                S_EMIT0: begin
                    if (!r_diff[0]) begin
                        r_state <= S_EMIT1;
                    end else if (w_out_free) begin
                        r_out          <= '{status: ST_OK, byte_index: 1'b0,
                                            byte_value: r_entry[0], last: !r_diff[1]};
                        r_last_sent[0] <= r_entry[0];
                        r_state        <= S_EMIT1;
                    end
                end
                S_EMIT1: begin
                    if (!r_diff[1]) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_out          <= '{status: ST_OK, byte_index: 1'b1,
                                            byte_value: r_entry[1], last: 1'b1};
                        r_last_sent[1] <= r_entry[1];
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `LBPE_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, w_accept, !o_in_ready)
    `LBPE_ASSERT_NOW(a_err_is_last, i_clk, i_rst_n,
        o_out_valid && o_out.status != ST_OK, o_out.last)
    `LBPE_ASSERT_NOW(a_byte1_is_last, i_clk, i_rst_n,
        o_out_valid && o_out.byte_index, o_out.last)
    `LBPE_ASSERT_NEXT(a_more_follows, i_clk, i_rst_n,
        o_out_valid && i_out_ready && !o_out.last, o_out_valid)

endmodule

>>> verif/led_blink_pattern_engine_unit_tb.sv
// Self-checking testbench for led_blink_pattern_engine_unit: directed and random set/tick
// requests with random idling on both sides, checked against an in-bench pattern predictor.
// Depends on lbpe_pkg and the led_blink_pattern_engine_unit RTL.
module led_blink_pattern_engine_unit_tb;
    import lbpe_pkg::*;

    class led_pattern_scoreboard;
        logic [7:0] pattern [INTERVALS][2];
        logic [7:0] sent_byte [2];
        int         interval;
        t_out_item  pending_q [$];
        int         n_requests;
        int         errors;

        function new();
            foreach (pattern[i, j]) pattern[i][j] = 8'h00;
            sent_byte[0] = 8'h00;
            sent_byte[1] = 8'h00;
            interval     = 0;
            n_requests   = 0;
            errors       = 0;
        endfunction

        function t_out_item make_result(t_status st, logic idx, logic [7:0] value, logic fin);
            t_out_item res;
            res.status     = st;
            res.byte_index = idx;
            res.byte_value = value;
            res.last       = fin;
            return res;
        endfunction

        function void note_request(t_in_item req);
            t_status    st;
            int         slot;
            logic [7:0] field_mask;
            logic [7:0] on_bits;
            bit         lit;
            bit         diff0;
            bit         diff1;
            n_requests++;
            if (req.action == ACT_SET) begin
                st         = ST_OK;
                slot       = 0;
                field_mask = 8'h00;
                on_bits    = 8'h00;
                case (req.led_id)
                    LED_BOTTOM: begin
                        field_mask = MASK_BOTTOM;
                        on_bits    = (req.color == COLOR_AMBER) ? AMBER_BOTTOM : GREEN_BOTTOM;
                    end
                    LED_MIDDLE: begin
                        field_mask = MASK_MIDDLE;
                        on_bits    = (req.color == COLOR_AMBER) ? AMBER_MIDDLE : GREEN_MIDDLE;
                    end
                    LED_TOP: begin
                        slot       = 1;
                        field_mask = MASK_TOP;
                        on_bits    = (req.color == COLOR_AMBER) ? AMBER_TOP : GREEN_TOP;
                    end
                    default: st = ST_BAD_LED;
                endcase
                if (st == ST_OK && req.color == COLOR_BAD)
                    st = ST_BAD_COLOR;
                else if (st == ST_OK && req.blink_mode == MODE_BAD)
                    st = ST_BAD_MODE;
                if (st == ST_OK) begin
                    if (req.color == COLOR_OFF)
                        on_bits = 8'h00;
                    for (int i = 0; i < INTERVALS; i++) begin
                        case (req.blink_mode)
                            MODE_STEADY: lit = 1'b1;
                            MODE_SLOW:   lit = (i < HALF);
                            default:     lit = ((i % 2) == 1);
                        endcase
                        pattern[i][slot] = (pattern[i][slot] & ~field_mask)
                                         | (lit ? on_bits : 8'h00);
                    end
                end
                pending_q.push_back(make_result(st, 1'b0, 8'h00, 1'b1));
            end else begin
                interval = (interval + 1 >= INTERVALS) ? 0 : interval + 1;
                diff0 = (sent_byte[0] != pattern[interval][0]);
                diff1 = (sent_byte[1] != pattern[interval][1]);
                if (diff0) begin
                    pending_q.push_back(make_result(ST_OK, 1'b0, pattern[interval][0], !diff1));
                    sent_byte[0] = pattern[interval][0];
                end
                if (diff1) begin
                    pending_q.push_back(make_result(ST_OK, 1'b1, pattern[interval][1], 1'b1));
                    sent_byte[1] = pattern[interval][1];
                end
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result st=%0d idx=%0d val=%02h last=%0d",
                                          got.status, got.byte_index, got.byte_value, got.last));
                return;
            end
            want = pending_q.pop_front();
            if (got.status !== want.status || got.byte_index !== want.byte_index ||
                got.byte_value !== want.byte_value || got.last !== want.last)
                report_mismatch($sformatf(
                    "got st=%0d idx=%0d val=%02h last=%0d, want st=%0d idx=%0d val=%02h last=%0d",
                    got.status, got.byte_index, got.byte_value, got.last,
                    want.status, want.byte_index, want.byte_value, want.last));
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out;

    led_pattern_scoreboard sb = new();
    bit no_idle;

    led_blink_pattern_engine_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("led_blink_pattern_engine_unit_tb: FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic t_in_item random_request();
        t_in_item req;
        int       pick;
        pick = $urandom_range(0, 99);
        req  = t_in_item'(8'($urandom_range(0, 255)));
        if (pick < 40) begin
            req.action = ACT_TICK;
        end else if (pick < 88) begin
            req.action = ACT_SET;
            case ($urandom_range(0, 2))
                0:       req.led_id = LED_BOTTOM;
                1:       req.led_id = LED_MIDDLE;
                default: req.led_id = LED_TOP;
            endcase
            req.color      = 2'($urandom_range(0, 2));
            req.blink_mode = 2'($urandom_range(0, 2));
        end else begin
            req.action = ACT_SET;
        end
        return req;
    endfunction

    task automatic send_request(t_in_item req);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        i_in       <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(req);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic set_led(logic [2:0] led, logic [1:0] color, logic [1:0] mode);
        t_in_item req;
        req.action     = ACT_SET;
        req.led_id     = led;
        req.color      = color;
        req.blink_mode = mode;
        send_request(req);
    endtask

    task automatic tick();
        t_in_item req;
        req            = t_in_item'(8'($urandom_range(0, 255)));
        req.action     = ACT_TICK;
        send_request(req);
    endtask

    // result side: random ready, one long hold-off once 120 requests have been sent
    initial begin
        bit held;
        int run_len;
        int stall;
        int r;
        held        = 1'b0;
        i_out_ready = 1'b0;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (!held && sb.n_requests >= 120) begin
                held = 1'b1;
                repeat (400) begin
                    @(negedge i_clk);
                    i_out_ready <= 1'b0;
                end
            end
            r       = $urandom_range(0, 99);
            run_len = (r < 10) ? $urandom_range(100, 200) : $urandom_range(1, 12);
            repeat (run_len) begin
                @(negedge i_clk);
                i_out_ready <= 1'b1;
            end
            r     = $urandom_range(0, 99);
            stall = (r < 55) ? $urandom_range(0, 1) :
                    (r < 95) ? $urandom_range(2, 5) : $urandom_range(20, 60);
            repeat (stall) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out);
    end

    initial begin
        int drained;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        no_idle    = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tick();
        set_led(LED_BOTTOM, COLOR_AMBER, MODE_STEADY);
        tick();
        set_led(LED_MIDDLE, COLOR_GREEN, MODE_SLOW);
        set_led(LED_TOP, COLOR_AMBER, MODE_FAST);
        tick();
        tick();
        set_led(LED_TOP, COLOR_GREEN, MODE_STEADY);
        tick();
        set_led(LED_BOTTOM, COLOR_OFF, MODE_STEADY);
        tick();
        set_led(3'd0, COLOR_AMBER, MODE_STEADY);
        set_led(3'd2, COLOR_GREEN, MODE_SLOW);
        set_led(3'd5, COLOR_AMBER, MODE_FAST);
        set_led(3'd6, COLOR_OFF, MODE_STEADY);
        // bad led wins over bad colour and bad mode
        set_led(3'd7, COLOR_BAD, MODE_BAD);
        set_led(LED_BOTTOM, COLOR_BAD, MODE_BAD);
        set_led(LED_MIDDLE, COLOR_GREEN, MODE_BAD);
        set_led(LED_TOP, COLOR_OFF, MODE_FAST);
        repeat (6) tick();

        for (int n = 0; n < 750; n++) begin
            if (n % 50 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_request(random_request());
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        drained = 0;
        while (sb.pending_q.size() != 0 && drained < 3000) begin
            @(posedge i_clk);
            drained++;
        end
        if (sb.pending_q.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending_q.size()));
        repeat (40) @(posedge i_clk);

        if (sb.errors == 0)
            $display("led_blink_pattern_engine_unit_tb: PASS");
        else
            $display("led_blink_pattern_engine_unit_tb: FAIL");
        $finish;
    end
endmodule
